### design/multilevel_queue_process_scheduler_assert.svh
// assertion macros shared by the scheduler modules
// each expects clk and rst_n in scope
`ifndef MULTILEVEL_QUEUE_PROCESS_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_PROCESS_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MLQS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlqs: same-cycle check failed");

// next-cycle implication
`define MLQS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlqs: next-cycle check failed");

`endif

### design/mlqs_pkg.sv
`default_nettype none

package mlqs_pkg;

  // life states
  localparam logic [1:0] ST_NEW        = 2'd0;
  localparam logic [1:0] ST_RUNNABLE   = 2'd1;
  localparam logic [1:0] ST_RUNNING    = 2'd2;
  localparam logic [1:0] ST_TERMINATED = 2'd3;

  // request actions
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TERM = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LIMIT      = 2'd0;
  localparam logic [1:0] CFG_HIGH_FLOOR = 2'd1;
  localparam logic [1:0] CFG_MID_FLOOR  = 2'd2;

  localparam logic [3:0] LIMIT_RST      = 4'd5;
  localparam logic [7:0] HIGH_FLOOR_RST = 8'd20;
  localparam logic [7:0] MID_FLOOR_RST  = 8'd10;

  // bands
  localparam logic [1:0] BAND_NONE = 2'd0;
  localparam logic [1:0] BAND_HIGH = 2'd1;
  localparam logic [1:0] BAND_MID  = 2'd2;
  localparam logic [1:0] BAND_LOW  = 2'd3;

  // accumulate modes of a table pass
  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_COUNT = 3'd1;
  localparam logic [2:0] ACC_ADMIT = 3'd2;
  localparam logic [2:0] ACC_BAND  = 3'd3;
  localparam logic [2:0] ACC_GRANT = 3'd4;

  // entry write selects
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_LOAD   = 3'd1;
  localparam logic [2:0] WR_TERM   = 3'd2;
  localparam logic [2:0] WR_ADMIT  = 3'd3;
  localparam logic [2:0] WR_GRANT  = 3'd4;
  localparam logic [2:0] WR_REINIT = 3'd5;

  typedef struct packed {
    logic [1:0] life;
    logic [1:0] band;
    logic [7:0] prio;
  } entry_t;

  localparam entry_t ENTRY_RST = '{life: ST_TERMINATED, band: BAND_NONE, prio: 8'd0};

  typedef struct packed {
    logic       capture;
    logic       rd_entry;
    logic       scan_start;
    logic [2:0] acc;
    logic [2:0] wsel;
    logic       latch_band;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       idx_ok;
    logic       scan_done;
    logic       more_admit;
    logic       best_found;
    logic       band_none;
    logic       grant_due;
  } sts_t;

  function automatic logic [1:0] band_of(input logic [7:0] prio, input logic [7:0] hi,
                                         input logic [7:0] mid);
    logic [1:0] b;
    if (prio >= hi) begin
      b = BAND_HIGH;
    end else if (prio >= mid) begin
      b = BAND_MID;
    end else begin
      b = BAND_LOW;
    end
    return b;
  endfunction

  // tick must be a multiple of 2, 4 or 8 for the band to be served
  function automatic logic [2:0] tick_mask(input logic [1:0] band);
    logic [2:0] m;
    case (band)
      BAND_HIGH: m = 3'b001;
      BAND_MID:  m = 3'b011;
      default:   m = 3'b111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### design/mlqs_ram.sv
`default_nettype none

module mlqs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/mlqs_dp.sv
`default_nettype none
`include "multilevel_queue_process_scheduler_assert.svh"

module mlqs_dp #(
  parameter int NUM_ENTRIES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mlqs_pkg::cmd_t cmd,
  output mlqs_pkg::sts_t     sts,
  input  wire logic [1:0]    in_action,
  input  wire logic [2:0]    in_entry_index,
  input  wire logic [7:0]    in_priority_value,
  input  wire logic [31:0]   in_tick_value,
  input  wire logic          cfg_valid,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output logic               out_strobe,
  output logic               out_grant_valid,
  output logic [2:0]         out_grant_index,
  output logic [1:0]         out_band_served,
  output logic               out_reinitialized,
  output logic [3:0]         out_admitted_count
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam int KW = (CW > 4) ? CW : 4;
  localparam int EW = $bits(mlqs_pkg::entry_t);

  // captured request
  logic [1:0] act_r;
  logic [2:0] idx_r;
  logic [7:0] prio_in_r;
  logic [2:0] tick_lo_r;

  logic [3:0] limit_r;
  logic [7:0] hi_floor_r;
  logic [7:0] mid_floor_r;

  logic [NUM_ENTRIES-1:0] valid_r;

  // table pass: address counter and registered read pipe
  logic [IW-1:0] sa_r;
  logic          iss_r;
  logic          rv_r;
  logic [IW-1:0] ri_r;
  logic          rvb_r;

  logic [CW-1:0] fresh_r;
  logic [CW-1:0] live_r;
  logic [3:0]    adm_cnt_r;

  logic               best_found_r;
  logic [IW-1:0]      best_idx_r;
  mlqs_pkg::entry_t   best_r;
  logic [2:0]         bflag_r;

  logic       band_r;
  logic [1:0] band_sel_r;
  logic       rein_r;
  logic       grant_r;
  logic [2:0] gidx_r;

  logic       out_strobe_r;
  logic       out_grant_r;
  logic [2:0] out_gidx_r;
  logic [1:0] out_band_r;
  logic       out_rein_r;
  logic [3:0] out_adm_r;

  logic [IW-1:0]    ent_addr;
  logic [IW-1:0]    rd_addr;
  logic [EW-1:0]    ram_q;
  mlqs_pkg::entry_t rec;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  mlqs_pkg::entry_t wr_data;
  logic [1:0]       band_sel;
  logic [KW-1:0]    free_k;
  logic [KW-1:0]    fresh_k;
  logic [KW-1:0]    live_k;
  logic [KW-1:0]    lim_k;
  logic [KW-1:0]    to_admit;

  assign ent_addr = IW'(idx_r);
  assign rd_addr  = cmd.rd_entry ? ent_addr : sa_r;
  // an entry never written reads as its reset value
  assign rec      = rvb_r ? mlqs_pkg::entry_t'(ram_q) : mlqs_pkg::ENTRY_RST;

  mlqs_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ent_addr;
    wr_data = rec;
    case (cmd.wsel)
      mlqs_pkg::WR_LOAD: begin
        wr_en        = 1'b1;
        wr_data.prio = prio_in_r;
      end
      mlqs_pkg::WR_TERM: begin
        wr_en        = 1'b1;
        wr_data.life = mlqs_pkg::ST_TERMINATED;
      end
      mlqs_pkg::WR_ADMIT: begin
        wr_en        = 1'b1;
        wr_addr      = best_idx_r;
        wr_data      = best_r;
        wr_data.life = mlqs_pkg::ST_RUNNABLE;
      end
      mlqs_pkg::WR_GRANT: begin
        wr_en        = 1'b1;
        wr_addr      = best_idx_r;
        wr_data      = best_r;
        wr_data.life = mlqs_pkg::ST_RUNNING;
      end
      mlqs_pkg::WR_REINIT: begin
        wr_en        = rv_r;
        wr_addr      = ri_r;
        wr_data.life = mlqs_pkg::ST_NEW;
        wr_data.band = mlqs_pkg::band_of(rec.prio, hi_floor_r, mid_floor_r);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // free slots saturate at zero
  always_comb begin
    lim_k    = KW'(limit_r);
    live_k   = KW'(live_r);
    fresh_k  = KW'(fresh_r);
    free_k   = (lim_k > live_k) ? (lim_k - live_k) : '0;
    to_admit = (free_k < fresh_k) ? free_k : fresh_k;
  end

  always_comb begin
    if (bflag_r[0]) begin
      band_sel = mlqs_pkg::BAND_HIGH;
    end else if (bflag_r[1]) begin
      band_sel = mlqs_pkg::BAND_MID;
    end else if (bflag_r[2]) begin
      band_sel = mlqs_pkg::BAND_LOW;
    end else begin
      band_sel = mlqs_pkg::BAND_NONE;
    end
  end

  always_comb begin
    sts.action     = act_r;
    sts.idx_ok     = 32'(idx_r) < 32'(NUM_ENTRIES);
    sts.scan_done  = !iss_r && !rv_r;
    sts.more_admit = KW'(adm_cnt_r) < to_admit;
    sts.best_found = best_found_r;
    sts.band_none  = (band_sel == mlqs_pkg::BAND_NONE);
    sts.grant_due  = (band_sel != mlqs_pkg::BAND_NONE) &&
                     ((tick_lo_r & mlqs_pkg::tick_mask(band_sel)) == 3'b000);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= mlqs_pkg::LIMIT_RST;
      hi_floor_r  <= mlqs_pkg::HIGH_FLOOR_RST;
      mid_floor_r <= mlqs_pkg::MID_FLOOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mlqs_pkg::CFG_LIMIT:      limit_r     <= cfg_data[3:0];
        mlqs_pkg::CFG_HIGH_FLOOR: hi_floor_r  <= cfg_data;
        mlqs_pkg::CFG_MID_FLOOR:  mid_floor_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // valid bits and pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      iss_r   <= 1'b0;
      rv_r    <= 1'b0;
      sa_r    <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rv_r <= iss_r;
      if (cmd.scan_start) begin
        iss_r <= 1'b1;
        sa_r  <= '0;
      end else if (iss_r) begin
        if (sa_r == IW'(NUM_ENTRIES - 1)) begin
          iss_r <= 1'b0;
        end else begin
          sa_r <= sa_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ri_r  <= sa_r;
    rvb_r <= valid_r[rd_addr];
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r     <= in_action;
      idx_r     <= in_entry_index;
      prio_in_r <= in_priority_value;
      tick_lo_r <= in_tick_value[2:0];
      fresh_r   <= '0;
      live_r    <= '0;
      adm_cnt_r <= '0;
      band_r    <= 1'b0;
      rein_r    <= 1'b0;
      grant_r   <= 1'b0;
      gidx_r    <= '0;
    end
    if (cmd.scan_start) begin
      best_found_r <= 1'b0;
      bflag_r      <= '0;
    end
    if (rv_r) begin
      case (cmd.acc)
        mlqs_pkg::ACC_COUNT: begin
          if (rec.life == mlqs_pkg::ST_NEW) begin
            fresh_r <= fresh_r + CW'(1);
          end else if (rec.life != mlqs_pkg::ST_TERMINATED) begin
            live_r <= live_r + CW'(1);
          end
        end
        mlqs_pkg::ACC_ADMIT: begin
          if (rec.life == mlqs_pkg::ST_NEW && (!best_found_r || rec.prio > best_r.prio)) begin
            best_found_r <= 1'b1;
            best_idx_r   <= ri_r;
            best_r       <= rec;
          end
        end
        mlqs_pkg::ACC_BAND: begin
          if (rec.life != mlqs_pkg::ST_TERMINATED) begin
            case (rec.band)
              mlqs_pkg::BAND_HIGH: bflag_r[0] <= 1'b1;
              mlqs_pkg::BAND_MID:  bflag_r[1] <= 1'b1;
              mlqs_pkg::BAND_LOW:  bflag_r[2] <= 1'b1;
              default: begin
              end
            endcase
          end
        end
        mlqs_pkg::ACC_GRANT: begin
          // low band keeps the first runnable entry
          if (rec.band == band_sel_r && rec.life == mlqs_pkg::ST_RUNNABLE &&
              (!best_found_r ||
               (band_sel_r != mlqs_pkg::BAND_LOW && rec.prio > best_r.prio))) begin
            best_found_r <= 1'b1;
            best_idx_r   <= ri_r;
            best_r       <= rec;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.wsel == mlqs_pkg::WR_ADMIT) begin
      adm_cnt_r <= adm_cnt_r + 4'd1;
    end
    if (cmd.wsel == mlqs_pkg::WR_GRANT) begin
      grant_r <= 1'b1;
      gidx_r  <= 3'(best_idx_r);
    end
    if (cmd.latch_band) begin
      band_r     <= 1'b1;
      band_sel_r <= band_sel;
      rein_r     <= (band_sel == mlqs_pkg::BAND_NONE);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      out_grant_r  <= 1'b0;
      out_gidx_r   <= '0;
      out_band_r   <= mlqs_pkg::BAND_NONE;
      out_rein_r   <= 1'b0;
      out_adm_r    <= '0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.emit) begin
        out_grant_r <= grant_r;
        out_gidx_r  <= gidx_r;
        out_band_r  <= band_r ? band_sel_r : mlqs_pkg::BAND_NONE;
        out_rein_r  <= rein_r;
        out_adm_r   <= adm_cnt_r;
      end
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_grant_valid    = out_grant_r;
  assign out_grant_index    = out_gidx_r;
  assign out_band_served    = out_band_r;
  assign out_reinitialized  = out_rein_r;
  assign out_admitted_count = out_adm_r;

  `MLQS_ASSERT_IMP(a_adm_within_limit, out_strobe_r, out_adm_r <= limit_r)
  `MLQS_ASSERT_IMP(a_rein_no_grant, out_strobe_r && out_rein_r, !out_grant_r && out_band_r == mlqs_pkg::BAND_NONE)
  `MLQS_ASSERT_IMP(a_grant_has_band, out_strobe_r && out_grant_r, out_band_r != mlqs_pkg::BAND_NONE)

endmodule

`default_nettype wire

### design/mlqs_ctrl.sv
`default_nettype none
`include "multilevel_queue_process_scheduler_assert.svh"

module mlqs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire mlqs_pkg::sts_t sts,
  output mlqs_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_ENT_WR   = 4'd2;
  localparam logic [3:0] S_COUNT    = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_ADMIT    = 4'd5;
  localparam logic [3:0] S_ADMIT_WR = 4'd6;
  localparam logic [3:0] S_BAND     = 4'd7;
  localparam logic [3:0] S_GRANT    = 4'd8;
  localparam logic [3:0] S_GRANT_WR = 4'd9;
  localparam logic [3:0] S_REINIT   = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          mlqs_pkg::ACT_LOAD, mlqs_pkg::ACT_TERM: begin
            if (sts.idx_ok) begin
              cmd.rd_entry = 1'b1;
              state_nxt    = S_ENT_WR;
            end else begin
              state_nxt = S_DONE;
            end
          end
          mlqs_pkg::ACT_TICK: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_COUNT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ENT_WR: begin
        cmd.wsel  = (sts.action == mlqs_pkg::ACT_LOAD) ? mlqs_pkg::WR_LOAD : mlqs_pkg::WR_TERM;
        state_nxt = S_DONE;
      end
      S_COUNT: begin
        cmd.acc = mlqs_pkg::ACC_COUNT;
        if (sts.scan_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_start = 1'b1;
        state_nxt      = sts.more_admit ? S_ADMIT : S_BAND;
      end
      S_ADMIT: begin
        cmd.acc = mlqs_pkg::ACC_ADMIT;
        if (sts.scan_done) begin
          if (sts.best_found) begin
            state_nxt = S_ADMIT_WR;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_BAND;
          end
        end
      end
      S_ADMIT_WR: begin
        cmd.wsel  = mlqs_pkg::WR_ADMIT;
        state_nxt = S_CHECK;
      end
      S_BAND: begin
        cmd.acc = mlqs_pkg::ACC_BAND;
        if (sts.scan_done) begin
          cmd.latch_band = 1'b1;
          if (sts.band_none) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_REINIT;
          end else if (sts.grant_due) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_GRANT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_GRANT: begin
        cmd.acc = mlqs_pkg::ACC_GRANT;
        if (sts.scan_done) begin
          state_nxt = sts.best_found ? S_GRANT_WR : S_DONE;
        end
      end
      S_GRANT_WR: begin
        cmd.wsel  = mlqs_pkg::WR_GRANT;
        state_nxt = S_DONE;
      end
      S_REINIT: begin
        // rewrite each entry in the same pass, as its read data returns
        cmd.wsel = mlqs_pkg::WR_REINIT;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `MLQS_ASSERT_NXT(a_accept_dispatch, start && !busy, state_r == S_DISP)
  `MLQS_ASSERT_NXT(a_done_to_idle, state_r == S_DONE, state_r == S_IDLE)
  `MLQS_ASSERT_IMP(a_idle_quiet, state_r == S_IDLE, cmd.wsel == mlqs_pkg::WR_NONE && !cmd.emit)

endmodule

`default_nettype wire

### design/multilevel_queue_process_scheduler.sv
// load and terminate: dispatch with the entry read, entry write, then done; the result strobe is
// registered after done, and the next start is taken while it is high. A tick runs 2 + A passes
// over the entry memory (A = entries admitted), one more for a due grant search or the table
// rebuild, plus dispatch, A + 1 admission checks, A admission writes, the grant write and the
// emit state; the strobe is registered after emit; busy stays high until then, no result stalls
// synchronous reset loads limit 5, floors 20 and 10; every entry then reads terminated, priority 0
`default_nettype none

module multilevel_queue_process_scheduler #(
  parameter int NUM_ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [2:0]  in_entry_index,
  input  wire logic [7:0]  in_priority_value,
  input  wire logic [31:0] in_tick_value,
  output logic             out_strobe,
  output logic             out_grant_valid,
  output logic [2:0]       out_grant_index,
  output logic [1:0]       out_band_served,
  output logic             out_reinitialized,
  output logic [3:0]       out_admitted_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  mlqs_pkg::cmd_t cmd;
  mlqs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mlqs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mlqs_dp #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_priority_value  (in_priority_value),
    .in_tick_value      (in_tick_value),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_grant_valid    (out_grant_valid),
    .out_grant_index    (out_grant_index),
    .out_band_served    (out_band_served),
    .out_reinitialized  (out_reinitialized),
    .out_admitted_count (out_admitted_count)
  );

endmodule

`default_nettype wire

### bench/multilevel_queue_process_scheduler_tb.sv
`timescale 1ns / 100ps

module multilevel_queue_process_scheduler_tb;

  localparam int NUM_ENTRIES    = 8;
  localparam int NUM_PHASES     = 10;
  localparam int RAND_PER_PHASE = 150;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  idx;
    logic [7:0]  prio;
    logic [31:0] tick;
  } sched_req_t;

  typedef struct packed {
    logic       grant_valid;
    logic [2:0] grant_index;
    logic [1:0] band;
    logic       reinit;
    logic [3:0] admitted;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        out_strobe;
  logic        out_grant_valid;
  logic [2:0]  out_grant_index;
  logic [1:0]  out_band_served;
  logic        out_reinitialized;
  logic [3:0]  out_admitted_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  sched_req_t  drv_req = '0;

  // predictor copy of the process table and settings
  logic [1:0] tbl_life [NUM_ENTRIES];
  logic [7:0] tbl_prio [NUM_ENTRIES];
  logic [1:0] tbl_band [NUM_ENTRIES];
  logic [3:0] lim_cfg;
  logic [7:0] hi_floor;
  logic [7:0] mid_floor;

  sched_req_t request_backlog [$];
  sched_res_t pending_decisions [$];

  int errors = 0;
  int n_requests = 0;
  int n_ticks = 0;
  int n_grants = 0;
  int n_rebuilds = 0;
  int n_admitted = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;

  multilevel_queue_process_scheduler #(.NUM_ENTRIES(NUM_ENTRIES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (drv_req.action),
    .in_entry_index     (drv_req.idx),
    .in_priority_value  (drv_req.prio),
    .in_tick_value      (drv_req.tick),
    .out_strobe         (out_strobe),
    .out_grant_valid    (out_grant_valid),
    .out_grant_index    (out_grant_index),
    .out_band_served    (out_band_served),
    .out_reinitialized  (out_reinitialized),
    .out_admitted_count (out_admitted_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_table();
    int i;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      tbl_life[i] = mlqs_pkg::ST_TERMINATED;
      tbl_prio[i] = 8'd0;
      tbl_band[i] = mlqs_pkg::BAND_NONE;
    end
    lim_cfg   = mlqs_pkg::LIMIT_RST;
    hi_floor  = mlqs_pkg::HIGH_FLOOR_RST;
    mid_floor = mlqs_pkg::MID_FLOOR_RST;
  endfunction

  function automatic sched_res_t schedule_step(input sched_req_t rq);
    sched_res_t rs;
    int i, k, b, live, fresh, slots, to_admit, best, pick, admitted;
    logic [1:0] band;
    logic [2:0] mask;
    bit stop;
    rs = '0;
    case (rq.action)
      mlqs_pkg::ACT_LOAD: tbl_prio[rq.idx] = rq.prio;
      mlqs_pkg::ACT_TERM: tbl_life[rq.idx] = mlqs_pkg::ST_TERMINATED;
      mlqs_pkg::ACT_TICK: begin
        live = 0;
        fresh = 0;
        admitted = 0;
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (tbl_life[i] == mlqs_pkg::ST_NEW) begin
            fresh++;
          end else if (tbl_life[i] != mlqs_pkg::ST_TERMINATED) begin
            live++;
          end
        end
        slots = (int'(lim_cfg) > live) ? int'(lim_cfg) - live : 0;
        to_admit = (slots < fresh) ? slots : fresh;
        // admit highest priority first, lowest index on ties
        for (k = 0; k < to_admit; k++) begin
          best = -1;
          for (i = 0; i < NUM_ENTRIES; i++) begin
            if (tbl_life[i] == mlqs_pkg::ST_NEW &&
                (best < 0 || tbl_prio[i] > tbl_prio[best])) begin
              best = i;
            end
          end
          if (best >= 0) begin
            tbl_life[best] = mlqs_pkg::ST_RUNNABLE;
            admitted++;
          end
        end
        band = mlqs_pkg::BAND_NONE;
        for (b = 1; b <= 3 && band == mlqs_pkg::BAND_NONE; b++) begin
          for (i = 0; i < NUM_ENTRIES; i++) begin
            if (tbl_band[i] == b[1:0] && tbl_life[i] != mlqs_pkg::ST_TERMINATED) begin
              band = b[1:0];
            end
          end
        end
        if (band == mlqs_pkg::BAND_NONE) begin
          for (i = 0; i < NUM_ENTRIES; i++) begin
            tbl_life[i] = mlqs_pkg::ST_NEW;
            tbl_band[i] = (tbl_prio[i] >= hi_floor) ? mlqs_pkg::BAND_HIGH :
                          (tbl_prio[i] >= mid_floor) ? mlqs_pkg::BAND_MID : mlqs_pkg::BAND_LOW;
          end
          rs.reinit = 1'b1;
        end else begin
          mask = (band == mlqs_pkg::BAND_HIGH) ? 3'b001 :
                 (band == mlqs_pkg::BAND_MID) ? 3'b011 : 3'b111;
          if ((rq.tick[2:0] & mask) == 3'b000) begin
            pick = -1;
            stop = 1'b0;
            for (i = 0; i < NUM_ENTRIES; i++) begin
              if (!stop && tbl_band[i] == band && tbl_life[i] == mlqs_pkg::ST_RUNNABLE) begin
                if (pick < 0) begin
                  pick = i;
                  // low band takes the first runnable entry
                  stop = (band == mlqs_pkg::BAND_LOW);
                end else if (tbl_prio[i] > tbl_prio[pick]) begin
                  pick = i;
                end
              end
            end
            if (pick >= 0) begin
              tbl_life[pick] = mlqs_pkg::ST_RUNNING;
              rs.grant_valid = 1'b1;
              rs.grant_index = pick[2:0];
            end
          end
        end
        rs.band = band;
        rs.admitted = admitted[3:0];
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic sched_req_t mk_req(input logic [1:0] act, input logic [2:0] idx,
                                        input logic [7:0] prio, input logic [31:0] tick);
    sched_req_t rq;
    rq.action = act;
    rq.idx = idx;
    rq.prio = prio;
    rq.tick = tick;
    return rq;
  endfunction

  // mostly multiples of 8 so that every band gets served
  function automatic logic [31:0] rand_tick();
    logic [31:0] t;
    t = $urandom();
    if ($urandom_range(0, 1) == 0) begin
      t[2:0] = 3'b000;
    end
    return t;
  endfunction

  task automatic push_random(input int quota);
    int done_n, r, i;
    sched_req_t rq;
    done_n = 0;
    while (done_n < quota) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // clear the whole table, then tick to force a rebuild
        for (i = 0; i < NUM_ENTRIES; i++) begin
          request_backlog.push_back(mk_req(mlqs_pkg::ACT_TERM, i[2:0], 8'($urandom()),
                                           $urandom()));
        end
        request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'($urandom()), 8'($urandom()),
                                         rand_tick()));
        done_n += NUM_ENTRIES + 1;
      end else begin
        rq = mk_req(mlqs_pkg::ACT_TICK, 3'($urandom()), 8'($urandom()), rand_tick());
        r = $urandom_range(0, 99);
        if (r < 22) begin
          rq.action = mlqs_pkg::ACT_LOAD;
        end else if (r < 42) begin
          rq.action = mlqs_pkg::ACT_TERM;
        end else if (r >= 97) begin
          rq.action = ACT_UNUSED;
        end
        request_backlog.push_back(rq);
        if (rq.action != ACT_UNUSED) begin
          done_n++;
        end
      end
    end
  endtask

  task automatic push_directed();
    int i;
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd0, 8'd0, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_LOAD, 3'd0, 8'd255, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_LOAD, 3'd3, 8'd15, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_LOAD, 3'd5, 8'd20, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_LOAD, 3'd6, 8'd20, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_LOAD, 3'd7, 8'd0, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_LOAD, 3'd2, 8'd9, 32'd0));
    for (i = 0; i < NUM_ENTRIES; i++) begin
      request_backlog.push_back(mk_req(mlqs_pkg::ACT_TERM, i[2:0], 8'd0, 32'd0));
    end
    // rebuild with bands, then admit and grant with a priority tie in the high band
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd0, 8'd0, 32'd8));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd0, 8'd0, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd0, 8'd0, 32'd1));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd0, 8'd0, 32'd2));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TERM, 3'd0, 8'd0, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TERM, 3'd5, 8'd0, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TERM, 3'd6, 8'd0, 32'd0));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd0, 8'd0, 32'd4));
    request_backlog.push_back(mk_req(ACT_UNUSED, 3'd7, 8'd255, 32'hFFFF_FFFF));
    request_backlog.push_back(mk_req(mlqs_pkg::ACT_TICK, 3'd7, 8'd255, 32'hFFFF_FFFF));
  endtask

  task automatic drain_all();
    while (request_backlog.size() != 0 || pending_decisions.size() != 0 || start) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mlqs_pkg::CFG_LIMIT:      lim_cfg = data[3:0];
      mlqs_pkg::CFG_HIGH_FLOOR: hi_floor = data;
      mlqs_pkg::CFG_MID_FLOOR:  mid_floor = data;
      default: ;
    endcase
  endtask

  // driver: bursts of back-to-back requests separated by random gaps
  always @(posedge clk) begin : driver
    sched_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (start && !busy) begin
      pending_decisions.push_back(schedule_step(drv_req));
      n_requests++;
      if (drv_req.action == mlqs_pkg::ACT_TICK) begin
        n_ticks++;
      end
      if (burst_left > 0 && request_backlog.size() != 0) begin
        nxt = request_backlog.pop_front();
        drv_req <= nxt;
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(1, 25));
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (request_backlog.size() != 0) begin
        nxt = request_backlog.pop_front();
        drv_req <= nxt;
        start <= 1'b1;
        burst_left <= int'($urandom_range(0, 39));
      end
    end
  end

  always @(posedge clk) begin : monitor
    sched_res_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_grant_valid, out_grant_index, out_band_served, out_reinitialized,
             out_admitted_count};
      if (pending_decisions.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: grant %0b idx %0d band %0d reinit %0b admitted %0d",
                   got.grant_valid, got.grant_index, got.band, got.reinit, got.admitted);
        end
      end else begin
        want = pending_decisions.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: grant %0b/%0b idx %0d/%0d band %0d/%0d reinit %0b/%0b adm %0d/%0d",
                     want.grant_valid, got.grant_valid, want.grant_index, got.grant_index,
                     want.band, got.band, want.reinit, got.reinit,
                     want.admitted, got.admitted);
          end
        end
        if (want.grant_valid) begin
          n_grants++;
        end
        if (want.reinit) begin
          n_rebuilds++;
        end
        n_admitted += int'(want.admitted);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_decisions.size());
        $display("multilevel_queue_process_scheduler verification failed");
        $finish;
      end
    end
  end

  initial begin : sequencer
    int ph;
    logic [7:0] lim_d, hi_d, mid_d;
    clear_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        push_directed();
        drain_all();
      end else begin
        case (ph)
          1: begin lim_d = 8'h01; hi_d = 8'hFF; mid_d = 8'h00; end
          2: begin lim_d = 8'h08; hi_d = 8'h00; mid_d = 8'hFF; end
          3: begin lim_d = 8'hFF; hi_d = 8'hFF; mid_d = 8'hFF; end
          4: begin lim_d = 8'hF0; hi_d = 8'h00; mid_d = 8'h00; end
          default: begin
            lim_d = 8'(($urandom_range(0, 15) << 4) | $urandom_range(1, 8));
            mid_d = 8'($urandom_range(0, 255));
            hi_d  = 8'($urandom_range(32'(mid_d), 255));
          end
        endcase
        cfg_write(mlqs_pkg::CFG_LIMIT, lim_d);
        cfg_write(mlqs_pkg::CFG_HIGH_FLOOR, hi_d);
        cfg_write(mlqs_pkg::CFG_MID_FLOOR, mid_d);
      end
      // halfway through, the sender holds off until the block has answered everything
      push_random(RAND_PER_PHASE / 2);
      drain_all();
      push_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
      drain_all();
    end
    $display("%0d requests (%0d ticks) over %0d register settings", n_requests, n_ticks,
             NUM_PHASES);
    $display("%0d grants, %0d table rebuilds, %0d admissions, %0d mismatches", n_grants,
             n_rebuilds, n_admitted, errors);
    if (errors == 0 && pending_decisions.size() == 0) begin
      $display("multilevel_queue_process_scheduler verification clean");
    end else begin
      $display("multilevel_queue_process_scheduler verification failed");
    end
    $finish;
  end

endmodule
